### rtl/core/sof_pkg.sv
// ----------------------------------------------------------------------------
// sof_pkg
// Types, constants and neighbour helper for the Strahler order block.
// ----------------------------------------------------------------------------
package sof_pkg;

    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 64;
    localparam int COL_W     = 6;
    localparam int ROW_W     = 6;
    localparam int CELL_W    = COL_W + ROW_W;
    localparam int CELL_N    = GRID_COLS * GRID_ROWS;
    localparam int ORD_W     = 4;
    localparam int FLOW_W    = 4;

    localparam logic [ORD_W-1:0]  MAX_ORDER = 4'd15;
    localparam logic [ORD_W-1:0]  THR_RST   = 4'd5;
    localparam logic [FLOW_W-1:0] DIR_END   = 4'd8;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [FLOW_W-1:0] flow_code;
        logic              no_data;
    } t_in;

    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic [ORD_W-1:0] channel_order;
        logic             is_channel;
    } t_out;

    typedef struct packed {
        logic [CELL_W-1:0] loc;
        logic [2:0]        dir;
        logic [1:0]        ties;
        logic [ORD_W-1:0]  best;
    } t_frame;

    typedef struct packed {
        logic             ready;
        logic             res_valid;
        logic [ORD_W-1:0] res_order;
    } t_eng_sts;

    typedef struct packed {
        logic              hit;
        logic [CELL_W-1:0] loc;
    } t_nb;

    // Cell that would flow into cell c along direction d (lies opposite d).
    function automatic t_nb nb_of(input logic [CELL_W-1:0] c, input logic [2:0] d);
        logic [2:0]       k;
        logic [COL_W:0]   nc;
        logic [ROW_W:0]   nr;
        t_nb              r;
        k  = d + 3'd4;
        nc = {1'b0, c[COL_W-1:0]};
        nr = {1'b0, c[CELL_W-1:COL_W]};
        case (k)
            3'd0: begin nr = nr - 1'b1; end
            3'd1: begin nr = nr - 1'b1; nc = nc + 1'b1; end
            3'd2: begin nc = nc + 1'b1; end
            3'd3: begin nr = nr + 1'b1; nc = nc + 1'b1; end
            3'd4: begin nr = nr + 1'b1; end
            3'd5: begin nr = nr + 1'b1; nc = nc - 1'b1; end
            3'd6: begin nc = nc - 1'b1; end
            3'd7: begin nr = nr - 1'b1; nc = nc - 1'b1; end
            default: begin nc = nc; end
        endcase
        r.hit = (nc < (COL_W+1)'(GRID_COLS)) && (nr < (ROW_W+1)'(GRID_ROWS));
        r.loc = {nr[ROW_W-1:0], nc[COL_W-1:0]};
        return r;
    endfunction

endpackage

### rtl/core/sof_engine.sv
// ----------------------------------------------------------------------------
// sof_engine
// Cell, order and stack memories with the upstream walk sequencer.
// ----------------------------------------------------------------------------
module sof_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_acc,
    input  sof_pkg::t_in    i_req,
    input  logic            i_take,
    output sof_pkg::t_eng_sts o_sts
);
    import sof_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_QEV  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EV   = 3'd4;
    localparam logic [2:0] S_POP  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [FLOW_W:0]  cell_mem [CELL_N];
    logic [ORD_W:0]   ord_mem  [CELL_N];
    t_frame           stk_mem  [CELL_N];

    logic [2:0]        r_st, n_st;
    logic [CELL_W-1:0] r_clr, n_clr;
    logic [CELL_W-1:0] r_sp, n_sp;
    logic [CELL_W-1:0] r_cur, n_cur;
    logic [FLOW_W-1:0] r_dir, n_dir;
    logic [1:0]        r_ties, n_ties;
    logic [ORD_W-1:0]  r_best, n_best;
    logic [CELL_W-1:0] r_nb, n_nb;
    logic [ORD_W-1:0]  r_res, n_res;

    logic [FLOW_W:0]   r_cell_rd;
    logic [ORD_W:0]    r_ord_rd;
    t_frame            r_stk_rd;

    logic              rd_en;
    logic [CELL_W-1:0] rd_addr;
    logic              ow_en;
    logic [CELL_W-1:0] ow_addr;
    logic [ORD_W:0]    ow_data;
    logic              sw_en;
    logic              sr_en;
    logic [CELL_W-1:0] sr_addr;
    t_nb               nb;
    logic [ORD_W-1:0]  fin;
    logic [ORD_W-1:0]  o_rd;
    logic [CELL_W-1:0] req_cell;

    assign req_cell = {i_req.row, i_req.col};
    assign nb       = nb_of(r_cur, r_dir[2:0]);
    assign fin      = r_best + ORD_W'((r_ties == 2'd2) && (r_best < MAX_ORDER));
    assign o_rd     = r_ord_rd[ORD_W-1:0];

    always_comb begin
        n_st = r_st; n_clr = r_clr; n_sp = r_sp; n_cur = r_cur; n_dir = r_dir;
        n_ties = r_ties; n_best = r_best; n_nb = r_nb; n_res = r_res;
        rd_en = 1'b0; rd_addr = req_cell;
        ow_en = 1'b0; ow_addr = r_cur; ow_data = '0;
        sw_en = 1'b0; sr_en = 1'b0; sr_addr = r_sp - 1'b1;
        o_sts.ready     = (r_st == S_IDLE);
        o_sts.res_valid = 1'b0;
        o_sts.res_order = r_res;
        case (r_st)
            S_CLR: begin
                ow_en = 1'b1; ow_addr = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == CELL_W'(CELL_N - 1)) begin
                    n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_acc) begin
                    if (i_req.op == OP_QUERY) begin
                        rd_en = 1'b1;
                        n_cur = req_cell;
                        n_st  = S_QEV;
                    end else begin
                        o_sts.res_valid = 1'b1;
                        o_sts.res_order = '0;
                        if (i_req.op == OP_CLEAR) begin
                            n_clr = '0;
                            n_st  = S_CLR;
                        end
                    end
                end
            end
            S_QEV: begin
                if (r_cell_rd[0]) begin
                    n_res = '0; n_st = S_DONE;
                end else if (o_rd != '0) begin
                    n_res = o_rd; n_st = S_DONE;
                end else begin
                    ow_en = 1'b1; ow_data = {1'b1, {ORD_W{1'b0}}};
                    n_dir = '0; n_ties = '0; n_best = ORD_W'(1); n_sp = '0;
                    n_st = S_RD;
                end
            end
            S_RD: begin
                if (r_dir[3]) begin
                    ow_en = 1'b1; ow_data = {1'b0, fin};
                    if (r_sp == '0) begin
                        n_res = fin; n_st = S_DONE;
                    end else begin
                        sr_en = 1'b1;
                        n_sp  = r_sp - 1'b1;
                        n_st  = S_POP;
                    end
                end else if (!nb.hit) begin
                    n_dir = r_dir + 1'b1;
                end else begin
                    rd_en = 1'b1; rd_addr = nb.loc;
                    n_nb  = nb.loc;
                    n_st  = S_EV;
                end
            end
            S_EV: begin
                n_st  = S_RD;
                n_dir = r_dir + 1'b1;
                if (!r_cell_rd[0] && r_cell_rd[FLOW_W:1] == r_dir) begin
                    if (o_rd == '0) begin
                        if (!r_ord_rd[ORD_W]) begin
                            sw_en = 1'b1;
                            n_sp  = r_sp + 1'b1;
                            ow_en = 1'b1; ow_addr = r_nb;
                            ow_data = {1'b1, {ORD_W{1'b0}}};
                            n_cur = r_nb; n_dir = '0; n_ties = '0;
                            n_best = ORD_W'(1);
                        end
                    end else if (r_best < o_rd) begin
                        n_best = o_rd; n_ties = 2'd1;
                    end else if (r_best == o_rd && r_ties != 2'd2) begin
                        n_ties = r_ties + 1'b1;
                    end
                end
            end
            S_POP: begin
                n_cur  = r_stk_rd.loc;
                n_dir  = {1'b0, r_stk_rd.dir};
                n_ties = r_stk_rd.ties;
                n_best = r_stk_rd.best;
                n_st   = S_RD;
            end
            S_DONE: begin
                o_sts.res_valid = 1'b1;
                if (i_take) begin
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && i_req.op == OP_WRITE) begin
            cell_mem[req_cell] <= {i_req.flow_code, i_req.no_data};
        end
        if (rd_en) begin
            r_cell_rd <= cell_mem[rd_addr];
            r_ord_rd  <= ord_mem[rd_addr];
        end
        if (ow_en) begin
            ord_mem[ow_addr] <= ow_data;
        end
        if (sw_en) begin
            stk_mem[r_sp] <= '{loc: r_cur, dir: r_dir[2:0], ties: r_ties, best: r_best};
        end
        if (sr_en) begin
            r_stk_rd <= stk_mem[sr_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLR;
            r_clr <= '0;
            r_sp  <= '0;
        end else begin
            r_st  <= n_st;
            r_clr <= n_clr;
            r_sp  <= n_sp;
        end
        r_cur <= n_cur; r_dir <= n_dir; r_ties <= n_ties;
        r_best <= n_best; r_nb <= n_nb; r_res <= n_res;
    end

    a_idle_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_IDLE |-> r_sp == '0) else $error("stack not empty at idle");
    a_pop_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_POP |-> $past(r_st) == S_RD) else $error("pop out of sequence");
    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_CLR |-> !o_sts.res_valid && !o_sts.ready) else $error("clear not quiet");
    a_dir_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_RD || r_st == S_EV) |-> r_dir <= DIR_END) else $error("direction overrun");

endmodule

### rtl/core/strahler_order_on_flow_grid.sv
// ----------------------------------------------------------------------------
// strahler_order_on_flow_grid
// Memoised Strahler order on a 64 x 64 D8 flow grid with an upstream walk.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_stall    i_in_data  (t_in)
//   out       output     o_out_valid / i_out_stall  o_out_data (t_out)
//   cfg       input      i_cfg_wr_en                i_cfg_wr_data
//
// Write, clear and unused transactions: result in the cycle after acceptance.
// Query of a known or no-data cell: result after the memory read and done state; an unknown
// cell walks upstream, reading each in-grid neighbour, stepping over off-grid ones
// and closing each stacked frame with a pop; a descended neighbour is read again.
// Reset and clear sweep the order memory with input stalled.
// Inputs are taken only when the engine is idle and the output slot frees.
// ----------------------------------------------------------------------------
module strahler_order_on_flow_grid (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sof_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sof_pkg::t_out   o_out_data,
    input  logic            i_cfg_wr_en,
    input  logic [3:0]      i_cfg_wr_data
);
    import sof_pkg::*;

    logic             r_out_valid;
    t_out             r_out;
    logic [ORD_W-1:0] r_thr;
    logic             out_free;
    logic             in_acc;
    t_eng_sts         sts;
    logic [ORD_W-1:0] thr;
    t_out             res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !(sts.ready && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    sof_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_req   (i_in_data),
        .i_take  (out_free),
        .o_sts   (sts)
    );

    always_comb begin
        thr = (r_thr == '0) ? ORD_W'(1) : r_thr;
        res.order         = sts.res_order;
        res.is_channel    = (sts.res_order >= thr) && (sts.res_order != '0);
        res.channel_order = res.is_channel ? (sts.res_order + 1'b1 - thr) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_thr       <= THR_RST;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (out_free) begin
                r_out_valid <= sts.res_valid;
            end
        end
        if (out_free && sts.res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### sim/sof_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_checker
// Watches the input, output and threshold ports of the Strahler order block,
// keeps its own copy of the flow grid and memoised orders, works out the result
// of every accepted transaction and compares each returned result against it.
// ----------------------------------------------------------------------------
module sof_checker
    import sof_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out_data,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    output int          o_pending,
    output int          o_errors
);

    logic [3:0] flow_mem   [CELL_N];
    logic       nodata_mem [CELL_N];
    logic [3:0] order_mem  [CELL_N];
    logic       on_path    [CELL_N];
    int         stk_cell   [CELL_N];
    int         stk_dir    [CELL_N];
    int         stk_ties   [CELL_N];
    int         stk_best   [CELL_N];
    logic [3:0] threshold;
    t_out       expected_q [$];
    int         queued = 0;
    int         errors = 0;

    assign o_pending = queued;
    assign o_errors  = errors;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Neighbour lying opposite direction d that flows into cell c, or -1.
    function automatic int upstream_of(input int c, input int d);
        int k;
        int nc;
        int nr;
        int n;
        k  = (d + 4) & 7;
        nc = c % GRID_COLS;
        nr = c / GRID_COLS;
        if (k == 1 || k == 2 || k == 3) nc++;
        if (k == 5 || k == 6 || k == 7) nc--;
        if (k == 0 || k == 1 || k == 7) nr--;
        if (k == 3 || k == 4 || k == 5) nr++;
        if (nc < 0 || nc >= GRID_COLS || nr < 0 || nr >= GRID_ROWS) return -1;
        n = nr * GRID_COLS + nc;
        if (nodata_mem[n] || flow_mem[n] != 4'(d)) return -1;
        return n;
    endfunction

    function automatic logic [3:0] walk_order(input int start);
        int cur;
        int dir;
        int ties;
        int best;
        int sp;
        int nb;
        int o;
        int res;
        bit down;
        if (order_mem[start] != 0) return order_mem[start];
        sp = 0;
        cur = start; dir = 0; ties = 0; best = 1;
        on_path[start] = 1'b1;
        forever begin
            down = 1'b0;
            while (dir < 8) begin
                nb = upstream_of(cur, dir);
                if (nb >= 0) begin
                    o = order_mem[nb];
                    if (o == 0) begin
                        if (!on_path[nb] && sp < CELL_N) begin
                            stk_cell[sp] = cur; stk_dir[sp] = dir;
                            stk_ties[sp] = ties; stk_best[sp] = best;
                            sp++;
                            on_path[nb] = 1'b1;
                            cur = nb; dir = 0; ties = 0; best = 1;
                            down = 1'b1;
                            break;
                        end
                    end else if (best < o) begin
                        best = o;
                        ties = 1;
                    end else if (best == o) begin
                        ties++;
                    end
                end
                dir++;
            end
            if (!down) begin
                res = best;
                if (ties > 1 && res < MAX_ORDER) res++;
                order_mem[cur] = 4'(res);
                on_path[cur] = 1'b0;
                if (sp == 0) return 4'(res);
                sp--;
                cur = stk_cell[sp]; dir = stk_dir[sp];
                ties = stk_ties[sp]; best = stk_best[sp];
            end
        end
    endfunction

    function automatic t_out predict(input t_in x);
        t_out r;
        int idx;
        int ord;
        int thr;
        r = '0;
        idx = x.row * GRID_COLS + x.col;
        thr = (threshold == 0) ? 1 : threshold;
        case (x.op)
            OP_WRITE: begin
                flow_mem[idx] = x.flow_code;
                nodata_mem[idx] = x.no_data;
            end
            OP_QUERY: begin
                if (!nodata_mem[idx]) begin
                    ord = walk_order(idx);
                    r.order = 4'(ord);
                    if (ord >= thr) begin
                        r.is_channel = 1'b1;
                        r.channel_order = 4'(ord + 1 - thr);
                    end
                end
            end
            OP_CLEAR: begin
                foreach (order_mem[i]) begin
                    order_mem[i] = '0;
                    on_path[i] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    initial begin
        foreach (order_mem[i]) begin
            flow_mem[i] = '0; nodata_mem[i] = 1'b0;
            order_mem[i] = '0; on_path[i] = 1'b0;
        end
        threshold = THR_RST;
    end

    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            foreach (order_mem[i]) begin
                order_mem[i] = '0;
                on_path[i] = 1'b0;
            end
            threshold = THR_RST;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) threshold = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) expected_q.push_back(predict(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    e = expected_q.pop_front();
                    if (i_out_data.order !== e.order)
                        report($sformatf("order %0d, expected %0d",
                                         i_out_data.order, e.order));
                    if (i_out_data.channel_order !== e.channel_order)
                        report($sformatf("channel_order %0d, expected %0d",
                                         i_out_data.channel_order, e.channel_order));
                    if (i_out_data.is_channel !== e.is_channel)
                        report($sformatf("is_channel %0b, expected %0b",
                                         i_out_data.is_channel, e.is_channel));
                end
            end
        end
        queued = expected_q.size();
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the Strahler order block: fills a band of rows at the top and
// at the bottom of the flow grid, each closed by a row of no-data cells, runs
// directed and random writes, queries and clears inside the bands under several
// thresholds, with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import sof_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int SWEEP_WAIT  = 4200;
    localparam int BAND_ROWS   = 4;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in         in_data;
    logic        out_valid;
    logic        out_stall;
    t_out        out_data;
    logic        cfg_wr_en;
    logic [3:0]  cfg_wr_data;
    int          pending;
    int          errors;
    int          cycles = 0;
    bit          quiet;
    bit          hold_req;

    strahler_order_on_flow_grid dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    sof_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        bit held;
        held = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (500) @(negedge i_clk);
                out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send(input t_in x);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= x;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_in cell_op(input logic [1:0] op, input int c, input int r,
                                    input int fc, input int nd);
        t_in x;
        x.op = op; x.col = 6'(c); x.row = 6'(r);
        x.flow_code = 4'(fc); x.no_data = (nd != 0);
        return x;
    endfunction

    // A row inside the top or the bottom band.
    function automatic int band_row();
        int r;
        r = $urandom_range(0, 2 * BAND_ROWS - 1);
        return (r < BAND_ROWS) ? r : r + GRID_ROWS - 2 * BAND_ROWS;
    endfunction

    // Mostly southward flow so that trees converge over long chains.
    function automatic t_in random_write(input int c, input int r);
        int p;
        int fc;
        p = $urandom_range(0, 99);
        if (p < 70)      fc = $urandom_range(3, 5);
        else if (p < 80) fc = DIR_END;
        else if (p < 92) fc = $urandom_range(0, 7);
        else             fc = $urandom_range(9, 15);
        return cell_op(OP_WRITE, c, r, fc, ($urandom_range(0, 19) == 0) ? 1 : 0);
    endfunction

    task automatic set_threshold(input logic [3:0] v);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SWEEP_WAIT) @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_items(input int n);
        int p;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 299);
            if (i == n / 2 && !quiet) hold_req = 1'b1;
            if (p < 2)
                send(cell_op(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), 0, 0));
            else if (p < 8)
                send(cell_op(2'd3, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 15), $urandom_range(0, 1)));
            else if (p < 110)
                send(random_write($urandom_range(0, 63), band_row()));
            else
                send(cell_op(OP_QUERY, $urandom_range(0, 63), band_row(),
                             $urandom_range(0, 15), $urandom_range(0, 1)));
        end
    endtask

    initial begin
        quiet = 1'b0;
        hold_req = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < GRID_ROWS; r++) begin
            if (r < BAND_ROWS || r >= GRID_ROWS - BAND_ROWS) begin
                for (int c = 0; c < GRID_COLS; c++)
                    send(random_write(c, r));
            end else if (r == BAND_ROWS || r == GRID_ROWS - BAND_ROWS - 1) begin
                for (int c = 0; c < GRID_COLS; c++)
                    send(cell_op(OP_WRITE, c, r, DIR_END, 1));
            end
        end

        // Corners, no-data cell, flow codes past the end, stale order, op 3.
        send(cell_op(OP_QUERY, 0, 0, 0, 0));
        send(cell_op(OP_QUERY, 63, 63, 15, 1));
        send(cell_op(OP_QUERY, 63, 0, 0, 0));
        send(cell_op(OP_QUERY, 0, 63, 0, 0));
        send(cell_op(OP_WRITE, 10, 1, 4, 1));
        send(cell_op(OP_QUERY, 10, 1, 0, 0));
        send(cell_op(OP_WRITE, 10, 1, 15, 0));
        send(cell_op(OP_QUERY, 10, 1, 0, 0));
        send(cell_op(OP_WRITE, 10, 2, 0, 0));
        send(cell_op(OP_QUERY, 10, 2, 0, 0));
        send(cell_op(OP_WRITE, 20, 2, 8, 0));
        send(cell_op(OP_WRITE, 20, 1, 4, 0));
        send(cell_op(OP_WRITE, 21, 2, 4, 0));
        send(cell_op(OP_QUERY, 20, 1, 0, 0));
        send(cell_op(OP_WRITE, 20, 1, 0, 0));
        send(cell_op(OP_QUERY, 20, 1, 0, 0));
        send(cell_op(OP_QUERY, 20, 2, 0, 0));
        send(cell_op(2'd3, 63, 63, 15, 1));
        send(cell_op(OP_CLEAR, 0, 0, 0, 0));
        send(cell_op(OP_QUERY, 20, 2, 0, 0));
        send(cell_op(OP_QUERY, 32, 63, 0, 0));

        set_threshold(4'd0);
        random_items(140);
        set_threshold(4'd1);
        random_items(140);
        set_threshold(4'd15);
        random_items(140);
        set_threshold(4'd2);
        random_items(140);
        set_threshold(4'd3);
        quiet = 1'b1;
        random_items(140);
        in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/sof_pkg.sv
rtl/core/sof_engine.sv
rtl/core/strahler_order_on_flow_grid.sv
sim/sof_checker.sv
sim/tb_top.sv
